FILE: src/ccfd_pkg.sv
// Shared types, constants and functions of the COBS/CRC frame decoder.
// No dependencies; every module of the decoder imports this package.
package ccfd_pkg;

    localparam int MAX_FRAME_BYTES = 4096;

    localparam int LEN_W     = 13;
    localparam int PLEN_W    = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY  = 16'hA001;
    localparam logic [7:0]       CODE_LONG = 8'hFF;
    localparam logic [7:0]       DELIM     = 8'h00;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_FRAME_LONG   = 3'd1,
        ST_DECODED_LONG = 3'd2,
        ST_INVALID      = 3'd3,
        ST_SHORT        = 3'd4,
        ST_CRC_BAD      = 3'd5
    } frame_status_t;

    typedef struct packed {
        logic                is_status;
        logic [7:0]          data_byte;
        frame_status_t       frame_status;
        logic [PLEN_W-1:0]   payload_len;
    } result_t;

    typedef struct packed {
        logic [LEN_W-1:0] frame_limit;
        logic [LEN_W-1:0] decoded_limit;
    } limits_t;

    function automatic logic [LEN_W-1:0] limit_of(input logic [LEN_W-1:0] reg_value);
        logic [LEN_W-1:0] lim;
        if (int'(reg_value) < MAX_FRAME_BYTES)
            lim = reg_value;
        else
            lim = LEN_W'(MAX_FRAME_BYTES);
        return lim;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

FILE: src/cobs_crc_frame_decoder_top.sv
// Top level of the COBS frame decoder with CRC-16/MODBUS check.
// Depends on ccfd_pkg, ccfd_cfg and ccfd_core; holds the input and result registers.

// Accepts one encoded link byte per clock cycle while the output is not stalled, and produces
// at most one result per byte: a decoded payload byte (tuser low) or, at each 0x00 delimiter,
// a frame status with the payload length (tuser high). Each byte is held in the input register
// and the decode step writes its result into the output register, from which it transfers;
// the single decode step from input register to result register sets the sustained rate of
// one byte per cycle while m_axis_tready holds. Payload bytes leave two decoded bytes late, so
// the CRC trailer is never presented. Write the length limits through the configuration
// channel only while no frame bytes are in flight.
module cobs_crc_frame_decoder_top
    import ccfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    // encoded byte stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    // decoded stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [7:0] data_byte, [10:8] frame_status,
                                                 // [22:11] payload_len, [23] zero
    output logic                 m_axis_tuser    // [0] is_status
);

    limits_t    limits;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic       advance;
    logic       res_valid;
    result_t    res;

    ccfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    ccfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .limits    (limits),
        .res_valid (res_valid),
        .res       (res)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res_valid;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.is_status;
    assign m_axis_tdata  = {1'b0, out_reg.payload_len, out_reg.frame_status, out_reg.data_byte};

endmodule

FILE: src/ccfd_cfg.sv
// Configuration registers of the frame decoder: encoded and decoded length limits.
// Depends on ccfd_pkg; stores each limit already clipped to the frame size bound.
module ccfd_cfg
    import ccfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    output limits_t              limits
);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DECODED_LEN = CFG_IDX_W'(1);

    limits_t limits_reg;
    limits_t limits_next;

    assign cfg_ready = 1'b1;
    assign limits    = limits_reg;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid)
        begin
            if (cfg_index == CFG_MAX_FRAME_LEN)
                limits_next.frame_limit = limit_of(cfg_data);
            else if (cfg_index == CFG_MAX_DECODED_LEN)
                limits_next.decoded_limit = limit_of(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.frame_limit   <= limit_of(LEN_RESET);
            limits_reg.decoded_limit <= limit_of(LEN_RESET);
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

endmodule

FILE: src/ccfd_core.sv
// Frame state and per-byte decode step: COBS undo, CRC-16, two-byte delay, status.
// Depends on ccfd_pkg; result is combinational and is registered by the top level.
module ccfd_core
    import ccfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  limits_t    limits,
    output logic       res_valid,
    output result_t    res
);

    logic [7:0]       block_left_reg,   block_left_next;
    logic             zero_follows_reg, zero_follows_next;
    logic             at_start_reg,     at_start_next;
    logic [LEN_W-1:0] enc_count_reg,    enc_count_next;
    logic [LEN_W-1:0] dec_count_reg,    dec_count_next;
    logic [15:0]      crc_reg,          crc_next;
    logic [7:0]       delay_reg  [2];
    logic [7:0]       delay_next [2];
    logic [1:0]       fault_reg,        fault_next;

    logic [LEN_W-1:0] enc_inc;
    logic             frame_fault;
    logic             take;
    logic [7:0]       take_byte;

    always_comb
    begin
        block_left_next   = block_left_reg;
        zero_follows_next = zero_follows_reg;
        at_start_next     = at_start_reg;
        enc_count_next    = enc_count_reg;
        dec_count_next    = dec_count_reg;
        crc_next          = crc_reg;
        delay_next[0]     = delay_reg[0];
        delay_next[1]     = delay_reg[1];
        fault_next        = fault_reg;
        res_valid         = 1'b0;
        res               = '0;
        take              = 1'b0;
        take_byte         = 8'h00;

        enc_inc     = (enc_count_reg != COUNT_MAX) ? enc_count_reg + LEN_W'(1) : enc_count_reg;
        frame_fault = fault_reg[1] | (enc_inc > limits.frame_limit);

        if (rx_byte != DELIM)
        begin
            enc_count_next = enc_inc;
            fault_next[1]  = frame_fault;
            if (block_left_reg != 8'h00)
            begin
                take            = 1'b1;
                take_byte       = rx_byte;
                block_left_next = block_left_reg - 8'd1;
            end
            else
            begin
                take              = zero_follows_reg & ~at_start_reg;
                block_left_next   = rx_byte - 8'd1;
                zero_follows_next = (rx_byte != CODE_LONG);
                at_start_next     = 1'b0;
            end

            if (take)
            begin
                if (dec_count_reg >= limits.decoded_limit)
                begin
                    fault_next[0] = 1'b1;
                end
                else
                begin
                    crc_next = crc_byte(crc_reg, take_byte);
                    if (dec_count_reg >= LEN_W'(2))
                    begin
                        res_valid     = 1'b1;
                        res.data_byte = delay_reg[0];
                    end
                    delay_next[0]  = delay_reg[1];
                    delay_next[1]  = take_byte;
                    dec_count_next = dec_count_reg + LEN_W'(1);
                end
            end
        end
        else
        begin
            res_valid     = 1'b1;
            res.is_status = 1'b1;
            priority if (frame_fault)
                res.frame_status = ST_FRAME_LONG;
            else if (fault_reg[0])
                res.frame_status = ST_DECODED_LONG;
            else if (block_left_reg != 8'h00)
                res.frame_status = ST_INVALID;
            else if (dec_count_reg < LEN_W'(2))
                res.frame_status = ST_SHORT;
            else if (crc_reg != 16'h0000)
                res.frame_status = ST_CRC_BAD;
            else
            begin
                res.frame_status = ST_OK;
                res.payload_len  = PLEN_W'(dec_count_reg - LEN_W'(2));
            end

            block_left_next   = 8'h00;
            zero_follows_next = 1'b0;
            at_start_next     = 1'b1;
            enc_count_next    = '0;
            dec_count_next    = '0;
            crc_next          = CRC_INIT;
            delay_next[0]     = 8'h00;
            delay_next[1]     = 8'h00;
            fault_next        = 2'b00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_left_reg   <= 8'h00;
            zero_follows_reg <= 1'b0;
            at_start_reg     <= 1'b1;
            enc_count_reg    <= '0;
            dec_count_reg    <= '0;
            crc_reg          <= CRC_INIT;
            delay_reg[0]     <= 8'h00;
            delay_reg[1]     <= 8'h00;
            fault_reg        <= 2'b00;
        end
        else if (step)
        begin
            block_left_reg   <= block_left_next;
            zero_follows_reg <= zero_follows_next;
            at_start_reg     <= at_start_next;
            enc_count_reg    <= enc_count_next;
            dec_count_reg    <= dec_count_next;
            crc_reg          <= crc_next;
            delay_reg[0]     <= delay_next[0];
            delay_reg[1]     <= delay_next[1];
            fault_reg        <= fault_next;
        end
    end

    a_delim_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && rx_byte == DELIM) |=>
            (dec_count_reg == '0 && crc_reg == CRC_INIT && at_start_reg && fault_reg == 2'b00))
        else $error("frame state not cleared after delimiter");

    a_delim_status: assert property (@(posedge clk) disable iff (!rst_n)
        (step && rx_byte == DELIM) |-> (res_valid && res.is_status))
        else $error("delimiter without status result");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.is_status) |->
            (res.frame_status == ST_OK && res.payload_len == '0 && rx_byte != DELIM))
        else $error("payload result carries status fields");

    a_block_not_start: assert property (@(posedge clk) disable iff (!rst_n)
        (block_left_reg != 8'h00) |-> !at_start_reg)
        else $error("open block at frame start");

endmodule

FILE: sim/tb_cobs_crc_frame_decoder_top.sv
// Testbench for cobs_crc_frame_decoder_top: a directed table, then random COBS frames
// with CRC-16/MODBUS trailers under several length limits, with random stalls on both sides.
// Depends on ccfd_pkg and the decoder RTL; results are checked against typed rows and a local predictor.
module tb_cobs_crc_frame_decoder_top;
    import ccfd_pkg::*;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        TYPED
    } row_check_t;

    typedef struct {
        logic [7:0] rx;
        row_check_t check;
        result_t    want;
    } stim_row_t;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECODED_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE2      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3      = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;
    logic                 m_axis_tuser;

    // predictor state
    logic [LEN_W-1:0] frame_len_reg;
    logic [LEN_W-1:0] decoded_len_reg;
    logic [7:0]       block_bytes_left;
    logic             implied_zero;
    logic             frame_opening;
    logic [LEN_W-1:0] link_count;
    logic [LEN_W-1:0] payload_count;
    logic [15:0]      running_crc;
    logic [7:0]       lag_bytes [2];
    logic             decoded_overrun;
    logic             encoded_overrun;

    result_t   awaited_results[$];
    stim_row_t directed_rows[$];
    logic [7:0] frame_bytes[$];
    logic [7:0] link_bytes[$];
    logic [7:0] block_run[$];
    int         mismatches;
    int         bytes_sent;
    bit         steady;

    cobs_crc_frame_decoder_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAIL cobs_crc_frame_decoder_top");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [15:0] crc16_modbus_next(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] x;
        logic        fb;
        int          k;
        x = c;
        for (k = 0; k < 8; k++)
        begin
            fb = x[0] ^ d[k];
            x  = x >> 1;
            if (fb)
                x = x ^ CRC_POLY;
        end
        return x;
    endfunction

    function automatic int effective_limit(input logic [LEN_W-1:0] v);
        return (int'(v) < MAX_FRAME_BYTES) ? int'(v) : MAX_FRAME_BYTES;
    endfunction

    function automatic void clear_frame_state();
        block_bytes_left = 8'd0;
        implied_zero     = 1'b0;
        frame_opening    = 1'b1;
        link_count       = '0;
        payload_count    = '0;
        running_crc      = CRC_INIT;
        lag_bytes[0]     = 8'd0;
        lag_bytes[1]     = 8'd0;
        decoded_overrun  = 1'b0;
        encoded_overrun  = 1'b0;
    endfunction

    // Feed one decoded byte through the CRC and the two-byte delay line.
    function automatic bit accept_decoded(input logic [7:0] d, output result_t r);
        bit emit;
        r    = '0;
        emit = 1'b0;
        if (int'(payload_count) >= effective_limit(decoded_len_reg))
        begin
            decoded_overrun = 1'b1;
            return 1'b0;
        end
        running_crc = crc16_modbus_next(running_crc, d);
        if (payload_count >= 2)
        begin
            emit        = 1'b1;
            r.data_byte = lag_bytes[0];
        end
        lag_bytes[0] = lag_bytes[1];
        lag_bytes[1] = d;
        payload_count++;
        return emit;
    endfunction

    function automatic bit decoder_step(input logic [7:0] b, output result_t r);
        bit emit;
        r    = '0;
        emit = 1'b0;
        if (link_count != COUNT_MAX)
            link_count++;
        if (int'(link_count) > effective_limit(frame_len_reg))
            encoded_overrun = 1'b1;
        if (b != DELIM)
        begin
            if (block_bytes_left != 0)
            begin
                block_bytes_left--;
                emit = accept_decoded(b, r);
            end
            else
            begin
                if (implied_zero && !frame_opening)
                    emit = accept_decoded(8'h00, r);
                block_bytes_left = b - 8'd1;
                implied_zero     = (b != CODE_LONG);
                frame_opening    = 1'b0;
            end
        end
        else
        begin
            r.is_status = 1'b1;
            if (encoded_overrun)
                r.frame_status = ST_FRAME_LONG;
            else if (decoded_overrun)
                r.frame_status = ST_DECODED_LONG;
            else if (block_bytes_left != 0)
                r.frame_status = ST_INVALID;
            else if (payload_count < 2)
                r.frame_status = ST_SHORT;
            else if (running_crc != 16'h0000)
                r.frame_status = ST_CRC_BAD;
            else
            begin
                r.frame_status = ST_OK;
                r.payload_len  = PLEN_W'(payload_count - 2);
            end
            emit = 1'b1;
            clear_frame_state();
        end
        return emit;
    endfunction

    function automatic void add_row(input logic [7:0] b, input row_check_t c, input logic st,
                                    input logic [7:0] d, input frame_status_t fs,
                                    input logic [PLEN_W-1:0] len);
        stim_row_t e;
        e.rx                = b;
        e.check             = c;
        e.want              = '0;
        e.want.is_status    = st;
        e.want.data_byte    = d;
        e.want.frame_status = fs;
        e.want.payload_len  = len;
        directed_rows.push_back(e);
    endfunction

    function automatic void make_payload(input int len, input int zero_pct);
        frame_bytes.delete();
        repeat (len)
            frame_bytes.push_back(($urandom_range(0, 99) < zero_pct) ? 8'h00
                                                                    : 8'($urandom_range(1, 255)));
    endfunction

    function automatic void append_trailer();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_bytes[i])
            c = crc16_modbus_next(c, frame_bytes[i]);
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endfunction

    function automatic void flush_run(input logic [7:0] code);
        link_bytes.push_back(code);
        foreach (block_run[i])
            link_bytes.push_back(block_run[i]);
        block_run.delete();
    endfunction

    function automatic void stuff_frame();
        link_bytes.delete();
        block_run.delete();
        foreach (frame_bytes[i])
        begin
            if (frame_bytes[i] == 8'h00)
                flush_run(8'(block_run.size() + 1));
            else
            begin
                block_run.push_back(frame_bytes[i]);
                if (block_run.size() == 254)
                    flush_run(CODE_LONG);
            end
        end
        flush_run(8'(block_run.size() + 1));
    endfunction

    task automatic send_byte(input logic [7:0] b, input row_check_t chk, input result_t typed);
        int      gap;
        bit      has;
        result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        has = decoder_step(b, predicted);
        if (chk == TYPED)
            awaited_results.push_back(typed);
        else if (chk == BY_MODEL && has)
            awaited_results.push_back(predicted);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_FRAME_LEN)
            frame_len_reg = v;
        else if (idx == REG_DECODED_LEN)
            decoded_len_reg = v;
        @(negedge clk);
    endtask

    // Drain the decoder, then rewrite both limits.
    task automatic set_limits(input logic [LEN_W-1:0] f, input logic [LEN_W-1:0] d,
                              input bit spare);
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        write_reg(REG_FRAME_LEN, f);
        write_reg(REG_DECODED_LEN, d);
        if (spare)
        begin
            write_reg(REG_SPARE2, LEN_W'($urandom_range(0, 8191)));
            write_reg(REG_SPARE3, LEN_W'($urandom_range(0, 8191)));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int budget);
        int stop;
        int r;
        int q;
        int len;
        int zpct;
        stop = bytes_sent + budget;
        while (bytes_sent < stop)
        begin
            steady = ($urandom_range(0, 4) == 0);
            r      = $urandom_range(0, 99);
            if (r < 88)
            begin
                q = $urandom_range(0, 99);
                if (q < 70)
                    len = $urandom_range(0, 12);
                else if (q < 96)
                    len = $urandom_range(13, 60);
                else
                    len = $urandom_range(240, 300);
                case ($urandom_range(0, 3))
                    0: zpct = 0;
                    1: zpct = 5;
                    2: zpct = 20;
                    default: zpct = 50;
                endcase
                make_payload(len, zpct);
                if (r < 80)
                    append_trailer();
                // corrupt one bit of a frame
                if (r >= 64 && r < 74 && frame_bytes.size() > 0)
                    frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] ^=
                        8'(1 << $urandom_range(0, 7));
                stuff_frame();
                // cut the frame short
                if (r >= 74 && r < 80 && link_bytes.size() > 1)
                    repeat ($urandom_range(1, link_bytes.size() - 1))
                        void'(link_bytes.pop_back());
            end
            else if (r < 95)
            begin
                link_bytes.delete();
                repeat ($urandom_range(1, 10))
                    link_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                link_bytes.delete();
                repeat ($urandom_range(0, 2))
                    link_bytes.push_back(DELIM);
            end
            link_bytes.push_back(DELIM);
            foreach (link_bytes[i])
                send_byte(link_bytes[i], BY_MODEL, '0);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int stall;
        int burst;
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            burst = $urandom_range(1, 12);
            repeat (burst) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.is_status    = m_axis_tuser;
            got.data_byte    = m_axis_tdata[7:0];
            got.frame_status = frame_status_t'(m_axis_tdata[10:8]);
            got.payload_len  = m_axis_tdata[22:11];
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected transfer: tuser=%b tdata=%h",
                             $time, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.is_status !== want.is_status || got.data_byte !== want.data_byte ||
                    got.frame_status !== want.frame_status ||
                    got.payload_len !== want.payload_len || m_axis_tdata[23] !== 1'b0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch: want %b %h %0d %0d, got %b %h %0d %0d pad %b",
                                 $time, want.is_status, want.data_byte, want.frame_status,
                                 want.payload_len, got.is_status, got.data_byte,
                                 got.frame_status, got.payload_len, m_axis_tdata[23]);
                end
            end
        end
    end

    initial
    begin
        int k;
        cfg_valid     = 1'b0;
        cfg_index     = REG_FRAME_LEN;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        rst_n         = 1'b0;
        mismatches    = 0;
        bytes_sent    = 0;
        steady        = 1'b0;
        frame_len_reg   = LEN_RESET;
        decoded_len_reg = LEN_RESET;
        clear_frame_state();

        // empty frame
        add_row(DELIM, TYPED, 1'b1, 8'h00, ST_SHORT, '0);
        // delimiter inside a block
        add_row(8'h03, NO_RESULT, 1'b0, 8'h00, ST_OK, '0);
        add_row(8'h11, NO_RESULT, 1'b0, 8'h00, ST_OK, '0);
        add_row(DELIM, TYPED, 1'b1, 8'h00, ST_INVALID, '0);
        // "123456789" with its MODBUS trailer 37 4B
        add_row(8'h0C, NO_RESULT, 1'b0, 8'h00, ST_OK, '0);
        add_row(8'h31, NO_RESULT, 1'b0, 8'h00, ST_OK, '0);
        add_row(8'h32, NO_RESULT, 1'b0, 8'h00, ST_OK, '0);
        for (k = 3; k <= 9; k++)
            add_row(8'(8'h30 + k), TYPED, 1'b0, 8'(8'h30 + k - 2), ST_OK, '0);
        add_row(8'h37, TYPED, 1'b0, 8'h38, ST_OK, '0);
        add_row(8'h4B, TYPED, 1'b0, 8'h39, ST_OK, '0);
        add_row(DELIM, TYPED, 1'b1, 8'h00, ST_OK, 12'd9);
        // long code cut by the delimiter
        add_row(CODE_LONG, NO_RESULT, 1'b0, 8'h00, ST_OK, '0);
        add_row(DELIM, TYPED, 1'b1, 8'h00, ST_INVALID, '0);
        // one implied zero only
        add_row(8'h01, NO_RESULT, 1'b0, 8'h00, ST_OK, '0);
        add_row(8'h01, NO_RESULT, 1'b0, 8'h00, ST_OK, '0);
        add_row(DELIM, TYPED, 1'b1, 8'h00, ST_SHORT, '0);
        // two bytes with no valid trailer
        add_row(8'h03, BY_MODEL, 1'b0, 8'h00, ST_OK, '0);
        add_row(8'h41, BY_MODEL, 1'b0, 8'h00, ST_OK, '0);
        add_row(8'h42, BY_MODEL, 1'b0, 8'h00, ST_OK, '0);
        add_row(DELIM, BY_MODEL, 1'b0, 8'h00, ST_OK, '0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].check, directed_rows[i].want);

        random_phase(220);

        set_limits(COUNT_MAX, COUNT_MAX, 1'b1);
        // one long frame, mostly full blocks
        make_payload($urandom_range(300, 600), 1);
        append_trailer();
        stuff_frame();
        link_bytes.push_back(DELIM);
        foreach (link_bytes[i])
            send_byte(link_bytes[i], BY_MODEL, '0);
        random_phase(160);

        set_limits(LEN_W'(0), LEN_W'(1), 1'b0);
        random_phase(80);
        set_limits(LEN_W'(24), LEN_RESET, 1'b0);
        random_phase(160);
        set_limits(LEN_RESET, LEN_W'(10), 1'b0);
        random_phase(160);
        set_limits(LEN_W'(2), LEN_W'(2), 1'b0);
        random_phase(80);
        set_limits(LEN_W'($urandom_range(16, 80)), LEN_W'($urandom_range(4, 60)), 1'b0);
        random_phase(160);
        set_limits(LEN_RESET, LEN_RESET, 1'b0);
        random_phase(160);

        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("PASS cobs_crc_frame_decoder_top");
        else
            $display("FAIL cobs_crc_frame_decoder_top");
        $finish;
    end

endmodule

FILE: files.f
src/ccfd_pkg.sv
src/ccfd_cfg.sv
src/ccfd_core.sv
src/cobs_crc_frame_decoder_top.sv
sim/tb_cobs_crc_frame_decoder_top.sv
